// ----- hw/rtl/adc_key_ladder_decoder_assert.svh -----
// assertion macros for the keypad decoder
`ifndef ADC_KEY_LADDER_DECODER_ASSERT_SVH
`define ADC_KEY_LADDER_DECODER_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define AKLD_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("akld assertion failed");

// next-cycle implication, sampled on i_clk, off during reset
`define AKLD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("akld assertion failed");

`endif

// ----- hw/rtl/akld_pkg.sv -----
// shared types and constants for the keypad decoder
package akld_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int KEY_W      = 3;
    localparam int SUM_W      = 16;
    localparam int COUNT_W    = 7;
    localparam int AVG_SHIFT  = 4;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;

    localparam logic [SAMPLE_W-1:0] JUMP_RESET = SAMPLE_W'(115);
    localparam logic [COUNT_W-1:0]  WINDOW_LEN = COUNT_W'(1 << AVG_SHIFT);

    localparam logic [KEY_W-1:0] KEY_WRONG   = KEY_W'(0);
    localparam logic [KEY_W-1:0] KEY_MUSIC   = KEY_W'(1);
    localparam logic [KEY_W-1:0] KEY_INC     = KEY_W'(2);
    localparam logic [KEY_W-1:0] KEY_DEC     = KEY_W'(3);
    localparam logic [KEY_W-1:0] KEY_GAME    = KEY_W'(4);
    localparam logic [KEY_W-1:0] KEY_CHANNEL = KEY_W'(5);
    localparam logic [KEY_W-1:0] KEY_POWER   = KEY_W'(6);

    localparam logic [SAMPLE_W-1:0] MUSIC_HI = SAMPLE_W'(865);
    localparam logic [SAMPLE_W-1:0] MUSIC_LO = SAMPLE_W'(825);
    localparam logic [SAMPLE_W-1:0] INC_HI   = SAMPLE_W'(760);
    localparam logic [SAMPLE_W-1:0] INC_LO   = SAMPLE_W'(720);
    localparam logic [SAMPLE_W-1:0] DEC_HI   = SAMPLE_W'(660);
    localparam logic [SAMPLE_W-1:0] DEC_LO   = SAMPLE_W'(620);
    localparam logic [SAMPLE_W-1:0] GAME_HI  = SAMPLE_W'(555);
    localparam logic [SAMPLE_W-1:0] GAME_LO  = SAMPLE_W'(515);
    localparam logic [SAMPLE_W-1:0] CHAN_HI  = SAMPLE_W'(380);
    localparam logic [SAMPLE_W-1:0] CHAN_LO  = SAMPLE_W'(340);

    typedef struct packed {
        logic                valid;
        logic [SAMPLE_W-1:0] sample;
    } t_item;

    typedef struct packed {
        logic                done;
        logic [SAMPLE_W-1:0] average;
    } t_win;

endpackage

// ----- hw/rtl/akld_in_stage.sv -----
// input register stage with stream handshake
module akld_in_stage (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [akld_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                           i_advance,
    output akld_pkg::t_item                o_item
);

    logic                          r_valid;
    logic                          n_valid;
    logic [akld_pkg::SAMPLE_W-1:0] r_sample;

    assign o_ready = !r_valid || i_advance;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sample <= i_sample;
        end
    end

    assign o_item.valid  = r_valid;
    assign o_item.sample = r_sample;

endmodule

// ----- hw/rtl/akld_accum.sv -----
// pulse filter, running sum and window counter
module akld_accum (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  akld_pkg::t_item                i_item,
    input  logic                           i_step,
    input  logic [akld_pkg::SAMPLE_W-1:0]  i_jump_limit,
    output akld_pkg::t_win                 o_win
);

    logic [akld_pkg::SAMPLE_W-1:0] r_prev;
    logic [akld_pkg::SUM_W-1:0]    r_sum;
    logic [akld_pkg::COUNT_W-1:0]  r_count;
    logic [akld_pkg::SAMPLE_W-1:0] n_prev;
    logic [akld_pkg::SUM_W-1:0]    n_sum;
    logic [akld_pkg::COUNT_W-1:0]  n_count;

    logic [akld_pkg::SAMPLE_W-1:0] w_diff;
    logic                          w_pulse;
    logic [akld_pkg::SUM_W-1:0]    w_sum_add;
    logic [akld_pkg::COUNT_W-1:0]  w_count_add;
    logic                          w_full;

    always_comb begin
        if (i_item.sample > r_prev) begin
            w_diff = i_item.sample - r_prev;
        end else begin
            w_diff = r_prev - i_item.sample;
        end
        w_pulse     = w_diff > i_jump_limit;
        w_sum_add   = r_sum + akld_pkg::SUM_W'(i_item.sample);
        w_count_add = r_count + akld_pkg::COUNT_W'(1);
        w_full      = !w_pulse && (w_count_add == akld_pkg::WINDOW_LEN);
    end

    always_comb begin
        n_prev  = r_prev;
        n_sum   = r_sum;
        n_count = r_count;
        if (i_step) begin
            n_prev = i_item.sample;
            if (w_pulse || w_full) begin
                n_sum   = '0;
                n_count = '0;
            end else begin
                n_sum   = w_sum_add;
                n_count = w_count_add;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_sum   <= '0;
            r_count <= '0;
        end else begin
            r_prev  <= n_prev;
            r_sum   <= n_sum;
            r_count <= n_count;
        end
    end

    assign o_win.done    = i_item.valid && w_full;
    assign o_win.average = w_sum_add[akld_pkg::AVG_SHIFT +: akld_pkg::SAMPLE_W];

endmodule

// ----- hw/rtl/akld_classify.sv -----
// maps a window average to a key code through fixed windows
module akld_classify (
    input  logic [akld_pkg::SAMPLE_W-1:0] i_average,
    output logic [akld_pkg::KEY_W-1:0]    o_key_code
);

    always_comb begin
        if (i_average > akld_pkg::MUSIC_HI) begin
            o_key_code = akld_pkg::KEY_WRONG;
        end else if (i_average > akld_pkg::MUSIC_LO) begin
            o_key_code = akld_pkg::KEY_MUSIC;
        end else if (i_average > akld_pkg::INC_HI) begin
            o_key_code = akld_pkg::KEY_WRONG;
        end else if (i_average > akld_pkg::INC_LO) begin
            o_key_code = akld_pkg::KEY_INC;
        end else if (i_average > akld_pkg::DEC_HI) begin
            o_key_code = akld_pkg::KEY_WRONG;
        end else if (i_average > akld_pkg::DEC_LO) begin
            o_key_code = akld_pkg::KEY_DEC;
        end else if (i_average > akld_pkg::GAME_HI) begin
            o_key_code = akld_pkg::KEY_WRONG;
        end else if (i_average > akld_pkg::GAME_LO) begin
            o_key_code = akld_pkg::KEY_GAME;
        end else if (i_average > akld_pkg::CHAN_HI) begin
            o_key_code = akld_pkg::KEY_WRONG;
        end else if (i_average > akld_pkg::CHAN_LO) begin
            o_key_code = akld_pkg::KEY_CHANNEL;
        end else if (i_average == '0) begin
            o_key_code = akld_pkg::KEY_POWER;
        end else begin
            o_key_code = akld_pkg::KEY_WRONG;
        end
    end

endmodule

// ----- hw/rtl/adc_key_ladder_decoder.sv -----
// top level of the resistor-ladder keypad decoder
// Takes one ADC sample word per clock unless the output stalls and gives a
// key code with its window average once every 2^AVG_SHIFT (16) samples that
// pass the jump filter; a sample that jumps by more than jump_limit from the
// previous one restarts the window and gives nothing. Sustained rate is one
// word per cycle while m_axis_tready keeps up: the compare/add path between
// the input register and the result register updates the previous-sample,
// sum and count registers; the classify path feeds the result register.
// jump_limit resets to 115; the user must write it through the cfg port only
// while the block is idle, which the block itself does not enforce.
module adc_key_ladder_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [akld_pkg::S_TDATA_W-1:0]  s_axis_tdata,   // [9:0] sample
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [akld_pkg::M_TDATA_W-1:0]  m_axis_tdata,   // [2:0] key_code, [12:3] average
    input  logic                            i_cfg_wr_en,
    input  logic [akld_pkg::SAMPLE_W-1:0]   i_cfg_wr_data
);

    logic [akld_pkg::SAMPLE_W-1:0] r_jump_limit;
    logic                          r_out_valid;
    logic                          n_out_valid;
    logic [akld_pkg::KEY_W-1:0]    r_out_key;
    logic [akld_pkg::SAMPLE_W-1:0] r_out_avg;

    logic                          w_advance;
    akld_pkg::t_item               w_item;
    akld_pkg::t_win                w_win;
    logic [akld_pkg::KEY_W-1:0]    w_key_code;

    assign w_advance = !r_out_valid || m_axis_tready;

    akld_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_sample  (s_axis_tdata[akld_pkg::SAMPLE_W-1:0]),
        .i_advance (w_advance),
        .o_item    (w_item)
    );

    akld_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_item),
        .i_step       (w_item.valid && w_advance),
        .i_jump_limit (r_jump_limit),
        .o_win        (w_win)
    );

    akld_classify u_classify (
        .i_average  (w_win.average),
        .o_key_code (w_key_code)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jump_limit <= akld_pkg::JUMP_RESET;
        end else if (i_cfg_wr_en) begin
            r_jump_limit <= i_cfg_wr_data;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_advance) begin
            n_out_valid = w_win.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_win.done) begin
            r_out_key <= w_key_code;
            r_out_avg <= w_win.average;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = akld_pkg::M_TDATA_W'({r_out_avg, r_out_key});

`include "adc_key_ladder_decoder_assert.svh"

    // no result word without a completed window
    `AKLD_ASSERT_NEXT(a_no_spurious_word, w_advance && !w_win.done, !m_axis_tvalid)

    // a zero average always decodes as power
    `AKLD_ASSERT(a_power_on_zero, m_axis_tvalid && (r_out_avg == '0),
                 r_out_key == akld_pkg::KEY_POWER)

    // key code never leaves the defined set
    `AKLD_ASSERT(a_key_in_range, m_axis_tvalid,
                 m_axis_tdata[akld_pkg::KEY_W-1:0] != {akld_pkg::KEY_W{1'b1}})

endmodule

// ----- tb/tb_top.sv -----
// testbench for the keypad ladder decoder: random sample streams against a window predictor
`timescale 1ns / 1ps

class key_scoreboard;
    typedef struct packed {
        logic [akld_pkg::SAMPLE_W-1:0] average;
        logic [akld_pkg::KEY_W-1:0]    key_code;
    } t_key_word;

    logic [akld_pkg::SAMPLE_W-1:0] jump_limit;
    logic [akld_pkg::SAMPLE_W-1:0] last_sample;
    logic [akld_pkg::SUM_W-1:0]    window_sum;
    logic [akld_pkg::COUNT_W-1:0]  window_count;
    t_key_word                     expected_keys[$];
    int                            errors;

    function new();
        jump_limit   = akld_pkg::SAMPLE_W'(115);
        last_sample  = '0;
        window_sum   = '0;
        window_count = '0;
        errors       = 0;
    endfunction

    function void set_jump_limit(logic [akld_pkg::SAMPLE_W-1:0] value);
        jump_limit = value;
    endfunction

    function int pending();
        return expected_keys.size();
    endfunction

    function logic [akld_pkg::KEY_W-1:0] key_for_average(logic [akld_pkg::SAMPLE_W-1:0] a);
        if (a > 865) return akld_pkg::KEY_WRONG;
        if (a > 825) return akld_pkg::KEY_MUSIC;
        if (a > 760) return akld_pkg::KEY_WRONG;
        if (a > 720) return akld_pkg::KEY_INC;
        if (a > 660) return akld_pkg::KEY_WRONG;
        if (a > 620) return akld_pkg::KEY_DEC;
        if (a > 555) return akld_pkg::KEY_WRONG;
        if (a > 515) return akld_pkg::KEY_GAME;
        if (a > 380) return akld_pkg::KEY_WRONG;
        if (a > 340) return akld_pkg::KEY_CHANNEL;
        if (a == 0) return akld_pkg::KEY_POWER;
        return akld_pkg::KEY_WRONG;
    endfunction

    function void note_sample(logic [akld_pkg::SAMPLE_W-1:0] s);
        logic [akld_pkg::SAMPLE_W-1:0] diff;
        t_key_word                     w;
        diff = (s > last_sample) ? s - last_sample : last_sample - s;
        last_sample = s;
        if (diff > jump_limit) begin
            window_sum   = '0;
            window_count = '0;
            return;
        end
        window_sum   = window_sum + akld_pkg::SUM_W'(s);
        window_count = window_count + 1'b1;
        if (window_count != (1 << akld_pkg::AVG_SHIFT)) return;
        w.average  = akld_pkg::SAMPLE_W'(window_sum >> akld_pkg::AVG_SHIFT);
        w.key_code = key_for_average(w.average);
        expected_keys.push_back(w);
        window_sum   = '0;
        window_count = '0;
    endfunction

    task report_mismatch(string msg);
        errors++;
        if (errors <= 40) $display("%0t ns: %s", $time, msg);
    endtask

    task check_result(logic [akld_pkg::M_TDATA_W-1:0] word);
        t_key_word got;
        t_key_word want;
        got = word[akld_pkg::KEY_W+akld_pkg::SAMPLE_W-1:0];
        if (expected_keys.size() == 0) begin
            report_mismatch($sformatf("unexpected word key %0d avg %0d",
                                      got.key_code, got.average));
            return;
        end
        want = expected_keys.pop_front();
        if (got.key_code !== want.key_code)
            report_mismatch($sformatf("key code %0d, expected %0d (avg %0d)",
                                      got.key_code, want.key_code, want.average));
        if (got.average !== want.average)
            report_mismatch($sformatf("average %0d, expected %0d",
                                      got.average, want.average));
    endtask

    task close_out();
        if (expected_keys.size() != 0)
            report_mismatch($sformatf("%0d key words never arrived", expected_keys.size()));
    endtask
endclass

module tb_top;

    localparam int LONG_HOLD   = 300;
    localparam int DRAIN       = 16;
    localparam int PHASE_WORDS = 190;

    typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [akld_pkg::S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [akld_pkg::M_TDATA_W-1:0]  m_axis_tdata;
    logic                            i_cfg_wr_en   = 1'b0;
    logic [akld_pkg::SAMPLE_W-1:0]   i_cfg_wr_data = '0;

    key_scoreboard sb = new();
    int            burst_left    = 0;
    int            hold_requests = 0;
    int            holds_done    = 0;
    int            words_sent    = 0;
    int            boundary_levels[23] = '{0, 1, 340, 341, 380, 381, 515, 516, 555, 556, 620,
                                           621, 660, 661, 720, 721, 760, 761, 825, 826, 865,
                                           866, 1023};

    always #5 i_clk = ~i_clk;

    adc_key_ladder_decoder u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [9:0] sample
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [2:0] key_code, [12:3] average
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    initial begin : rx_side
        t_rx_mode mode;
        int       mode_left;
        int       tick;
        mode      = RX_OPEN;
        mode_left = 0;
        tick      = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_requests != holds_done) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                holds_done++;
            end
            if (mode_left == 0) begin
                mode      = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            tick++;
            case (mode)
                RX_OPEN:   m_axis_tready <= 1'b1;
                RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
                RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:   m_axis_tready <= (tick % 5 == 0);
            endcase
        end
    end

    // entered and left at a falling edge
    task automatic send_word(input logic [akld_pkg::SAMPLE_W-1:0] s);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= akld_pkg::S_TDATA_W'(s);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_sample(s);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
    endtask

    task automatic write_jump_limit(input logic [akld_pkg::SAMPLE_W-1:0] value);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        sb.set_jump_limit(value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic send_level_run(input int level, input int len, input int noise,
                                  input int spike_pct);
        int v;
        for (int i = 0; i < len; i++) begin
            v = level + int'($urandom_range(0, 2 * noise)) - noise;
            if (int'($urandom_range(0, 99)) < spike_pct) v = $urandom_range(0, 1023);
            if (v < 0) v = 0;
            if (v > 1023) v = 1023;
            send_word(akld_pkg::SAMPLE_W'(v));
        end
    endtask

    task automatic random_phase(input int count);
        int start;
        int level;
        int len;
        int noise;
        int spike;
        int jl;
        start = words_sent;
        jl    = int'(sb.jump_limit);
        while (words_sent - start < count) begin
            level = ($urandom_range(0, 1) == 1) ? boundary_levels[$urandom_range(0, 22)]
                                                : $urandom_range(0, 1023);
            len   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 15) : $urandom_range(16, 48);
            noise = $urandom_range(0, (jl / 2 < 40) ? jl / 2 : 40);
            if ($urandom_range(0, 3) == 0) noise = 0;
            spike = ($urandom_range(0, 9) == 0) ? 10 : 0;
            if ($urandom_range(0, 19) == 0) noise = jl + 20;
            send_level_run(level, len, noise, spike);
        end
    endtask

    initial begin : stimulus
        int waited;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // first window against a zero history gives power
        repeat (16) send_word(akld_pkg::SAMPLE_W'(0));
        send_word(akld_pkg::SAMPLE_W'(1023));
        send_word(akld_pkg::SAMPLE_W'(908));
        send_word(akld_pkg::SAMPLE_W'(1023));
        send_word(akld_pkg::SAMPLE_W'(907));
        send_word(akld_pkg::SAMPLE_W'(792));
        send_word(akld_pkg::SAMPLE_W'(0));
        send_word(akld_pkg::SAMPLE_W'(115));
        send_word(akld_pkg::SAMPLE_W'(1));

        random_phase(PHASE_WORDS);

        write_jump_limit(akld_pkg::SAMPLE_W'(1023));
        hold_requests++;
        burst_left = 400;
        random_phase(PHASE_WORDS);

        write_jump_limit(akld_pkg::SAMPLE_W'(0));
        random_phase(PHASE_WORDS);

        write_jump_limit(akld_pkg::SAMPLE_W'($urandom_range(1, 1022)));
        random_phase(PHASE_WORDS);

        write_jump_limit(akld_pkg::SAMPLE_W'(115));
        random_phase(PHASE_WORDS);

        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < 20000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (DRAIN) @(negedge i_clk);
        sb.close_out();
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("FAIL");
        $finish;
    end
endmodule
